// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL. Each use names its own label, clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ----- src/sws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

    localparam int HISTORY  = 64;
    localparam int STAMP_W  = 64;
    localparam int DUR_W    = 32;
    localparam int VCNT_W   = 7;
    localparam int IDX_W    = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int CNT_W    = $clog2(HISTORY + 1);
    localparam int SUM_W    = DUR_W + IDX_W;
    localparam int STEP_W   = $clog2(SUM_W + 1);

    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- src/sliding_window_frame_time_stats.sv -----
// An accepted word passes through the update, scan and finish states. The result waits for
// the 38-step divider and the scan of fill_count entries, whichever ends later, and for room
// in the output register. A word is taken only after the previous one is done.
// Reset (aresetn, synchronous, active low) clears the state machine, fill count, sum, write
// pointer and output valid; the window memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_frame_time_stats (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sws_pkg::STAMP_W-1:0]   s_start_stamp,
    input  logic [sws_pkg::STAMP_W-1:0]   s_end_stamp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sws_pkg::DUR_W-1:0]     m_latest_ns,
    output logic [sws_pkg::DUR_W-1:0]     m_mean_ns,
    output logic [sws_pkg::DUR_W-1:0]     m_min_ns,
    output logic [sws_pkg::DUR_W-1:0]     m_max_ns,
    output logic [sws_pkg::VCNT_W-1:0]    m_valid_count,
    output logic                          m_clamped
);
    import sws_pkg::*;

    // Window of the last HISTORY durations. Written at the ring pointer, read once per
    // cycle with the data registered.
    logic [DUR_W-1:0] window_mem [HISTORY];
    logic [DUR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;

    state_t           state_reg, state_next;
    logic [DUR_W-1:0] dur_reg, dur_next;
    logic             clamp_reg, clamp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0] wpos_reg, wpos_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [DUR_W-1:0] min_reg, min_next;
    logic [DUR_W-1:0] max_reg, max_next;

    logic              m_valid_reg, m_valid_next;
    logic [DUR_W-1:0]  m_latest_reg, m_latest_next;
    logic [DUR_W-1:0]  m_mean_reg, m_mean_next;
    logic [DUR_W-1:0]  m_min_reg, m_min_next;
    logic [DUR_W-1:0]  m_max_reg, m_max_next;
    logic [VCNT_W-1:0] m_count_reg, m_count_next;
    logic              m_clamp_reg, m_clamp_next;

    logic [STAMP_W-1:0] stamp_diff;
    logic               win_full;
    logic [DUR_W-1:0]   old_dur;
    logic               scan_issue;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;

    // The mean is formed by an iterative divider that runs while the scan walks
    // the window.
    sws_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            window_mem[wpos_reg] <= dur_reg;
        end
        rd_data_reg <= window_mem[rd_addr];
    end

    assign stamp_diff = s_end_stamp - s_start_stamp;
    assign win_full   = (fill_reg == CNT_W'(HISTORY));
    // Only a full window evicts; before that the entry at the pointer was never written.
    assign old_dur    = win_full ? rd_data_reg : '0;
    assign scan_issue = (scan_idx_reg < fill_reg);

    // While idle the memory is addressed at the ring pointer, so the entry about to be
    // evicted is already in the read register when the update state starts.
    assign rd_addr = (state_reg == ST_SCAN) ? scan_idx_reg[IDX_W-1:0] : wpos_reg;

    always_comb begin
        state_next    = state_reg;
        dur_next      = dur_reg;
        clamp_next    = clamp_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        wpos_next     = wpos_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = 1'b0;
        min_next      = min_reg;
        max_next      = max_reg;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        s_ready       = 1'b0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_latest_next = m_latest_reg;
        m_mean_next   = m_mean_reg;
        m_min_next    = m_min_reg;
        m_max_next    = m_max_reg;
        m_count_next  = m_count_reg;
        m_clamp_next  = m_clamp_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // Durations that do not fit in 32 bits saturate and raise the flag.
                    if (|stamp_diff[STAMP_W-1:DUR_W]) begin
                        dur_next   = DUR_MAX;
                        clamp_next = 1'b1;
                    end else begin
                        dur_next   = stamp_diff[DUR_W-1:0];
                        clamp_next = 1'b0;
                    end
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // Evicted value leaves the sum as the new one enters, then the new
                // value is written into the ring.
                sum_next      = sum_reg - SUM_W'(old_dur) + SUM_W'(dur_reg);
                fill_next     = win_full ? fill_reg : fill_reg + CNT_W'(1);
                wpos_next     = (wpos_reg == IDX_W'(HISTORY - 1)) ? '0 : wpos_reg + IDX_W'(1);
                mem_we        = 1'b1;
                div_start     = 1'b1;
                scan_idx_next = '0;
                min_next      = DUR_MAX;
                max_next      = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                // Valid entries sit at indices 0 to fill_count - 1, one read per cycle.
                if (scan_issue) begin
                    rd_vld_next   = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    if (rd_data_reg < min_reg) begin
                        min_next = rd_data_reg;
                    end
                    if (rd_data_reg > max_reg) begin
                        max_next = rd_data_reg;
                    end
                end
                if (!scan_issue && !rd_vld_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Wait for the divider and for room in the output register.
                if (div_done && (!m_valid_reg || m_ready)) begin
                    m_valid_next  = 1'b1;
                    m_latest_next = dur_reg;
                    m_mean_next   = div_quo[DUR_W-1:0];
                    m_min_next    = min_reg;
                    m_max_next    = max_reg;
                    m_count_next  = VCNT_W'(fill_reg);
                    m_clamp_next  = clamp_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            sum_reg     <= '0;
            wpos_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            wpos_reg    <= wpos_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dur_reg      <= dur_next;
        clamp_reg    <= clamp_next;
        scan_idx_reg <= scan_idx_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        m_latest_reg <= m_latest_next;
        m_mean_reg   <= m_mean_next;
        m_min_reg    <= m_min_next;
        m_max_reg    <= m_max_next;
        m_count_reg  <= m_count_next;
        m_clamp_reg  <= m_clamp_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_latest_ns   = m_latest_reg;
    assign m_mean_ns     = m_mean_reg;
    assign m_min_ns      = m_min_reg;
    assign m_max_ns      = m_max_reg;
    assign m_valid_count = m_count_reg;
    assign m_clamped     = m_clamp_reg;

`include "assert_macros.svh"

    // The fill count never runs past the window depth.
    `ASSERT_SAME(a_fill_range, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(HISTORY))
    // A mean of values that fit in 32 bits must itself fit in 32 bits.
    `ASSERT_SAME(a_mean_fits, aclk, aresetn, (state_reg == ST_FINISH) && div_done,
        div_quo[SUM_W-1:DUR_W] == '0)
    // The newest duration and the mean lie between the reported minimum and maximum.
    `ASSERT_SAME(a_stats_order, aclk, aresetn, m_valid_reg,
        (m_min_reg <= m_latest_reg) && (m_latest_reg <= m_max_reg) &&
        (m_min_reg <= m_mean_reg) && (m_mean_reg <= m_max_reg))
    // Every update leaves a nonempty window for the scan and the divider.
    `ASSERT_NEXT(a_update_fills, aclk, aresetn, state_reg == ST_UPDATE, fill_reg != '0)

endmodule

`default_nettype wire

// ----- src/sws_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sws_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sws_pkg::SUM_W-1:0]   dividend,
    input  logic [sws_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [sws_pkg::SUM_W-1:0]   quotient
);
    import sws_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    dvs_reg;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      trial_sub;
    logic                trial_ge;
    logic [CNT_W-1:0]    rem_next;

    // Restoring division, one quotient bit per cycle, dividend shifted out MSB first.
    always_comb begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge  = (trial >= {1'b0, dvs_reg});
        trial_sub = trial - {1'b0, dvs_reg};
        rem_next  = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(SUM_W);
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[SUM_W-2:0], trial_ge};
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

// Testbench for the sliding-window frame time statistics block.
//
// A tracker object keeps its own copy of the duration window, the fill count
// and the running sum. Every word accepted on the input channel is fed to it,
// and it queues the statistics that the block must return for that frame.
// Every word taken from the result channel is compared, field by field, with
// the oldest queued expectation. Both channels idle at random, and the input
// side drains the block completely three times during the run.

typedef struct {
    logic [sws_pkg::DUR_W-1:0]  latest_ns;
    logic [sws_pkg::DUR_W-1:0]  mean_ns;
    logic [sws_pkg::DUR_W-1:0]  min_ns;
    logic [sws_pkg::DUR_W-1:0]  max_ns;
    logic [sws_pkg::VCNT_W-1:0] count;
    logic                       clamp;
} frame_stats_t;

class frame_stats_tracker;
    // Window of the most recent durations, its fill level, their sum and the
    // slot that the next duration goes into.
    bit [sws_pkg::DUR_W-1:0] durations [sws_pkg::HISTORY];
    int unsigned             fill;
    longint unsigned         window_sum;
    int unsigned             next_slot;
    frame_stats_t            pending_stats [$];
    int unsigned             mismatches;
    int unsigned             frames_noted;
    int unsigned             saturated_frames;
    int unsigned             results_checked;

    function new();
        fill             = 0;
        window_sum       = 0;
        next_slot        = 0;
        mismatches       = 0;
        frames_noted     = 0;
        saturated_frames = 0;
        results_checked  = 0;
    endfunction

    // Called for every accepted input word: update the window and queue the
    // statistics that the block must report for this frame.
    function void note_frame(bit [sws_pkg::STAMP_W-1:0] start_ns,
                             bit [sws_pkg::STAMP_W-1:0] end_ns);
        bit [sws_pkg::STAMP_W-1:0] span;
        bit [sws_pkg::DUR_W-1:0]   dur;
        bit                        sat;
        bit [sws_pkg::DUR_W-1:0]   lo;
        bit [sws_pkg::DUR_W-1:0]   hi;
        frame_stats_t              want;
        span = end_ns - start_ns;
        sat  = (span > 64'h0000_0000_FFFF_FFFF);
        dur  = sat ? sws_pkg::DUR_MAX : span[sws_pkg::DUR_W-1:0];
        // Once the window is full, the oldest duration leaves the sum before
        // the new one enters.
        if (fill >= sws_pkg::HISTORY) begin
            window_sum -= durations[next_slot];
            fill = sws_pkg::HISTORY;
        end else begin
            fill++;
        end
        durations[next_slot] = dur;
        window_sum += dur;
        next_slot = (next_slot + 1) % sws_pkg::HISTORY;
        // While filling, the valid entries sit at the low indices.
        lo = '1;
        hi = '0;
        for (int i = 0; i < fill; i++) begin
            if (durations[i] < lo) lo = durations[i];
            if (durations[i] > hi) hi = durations[i];
        end
        want.latest_ns = dur;
        want.mean_ns   = sws_pkg::DUR_W'(window_sum / fill);
        want.min_ns    = lo;
        want.max_ns    = hi;
        want.count     = fill[sws_pkg::VCNT_W-1:0];
        want.clamp     = sat;
        pending_stats.push_back(want);
        frames_noted++;
        if (sat) saturated_frames++;
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH at result %0d: %s", results_checked, what);
        mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // Called for every result word taken from the block.
    task check_stats(frame_stats_t got);
        frame_stats_t want;
        if (pending_stats.size() == 0) begin
            report_mismatch("result word arrived with no frame outstanding");
        end else begin
            want = pending_stats.pop_front();
            compare_field("latest_ns", got.latest_ns, want.latest_ns);
            compare_field("mean_ns", got.mean_ns, want.mean_ns);
            compare_field("min_ns", got.min_ns, want.min_ns);
            compare_field("max_ns", got.max_ns, want.max_ns);
            compare_field("valid_count", 32'(got.count), 32'(want.count));
            compare_field("clamped", 32'(got.clamp), 32'(want.clamp));
        end
        results_checked++;
    endtask
endclass

module testbench;

    // The random part of the run; the directed corner frames come on top.
    localparam int RANDOM_FRAMES = 1030;
    // The limit lies well above the slowest correct run, in which every frame waits out
    // the longest input gap, the longest result stall and the longest processing time.
    localparam int CYCLE_LIMIT = 1000000;
    // Longest processing time of one word, plus some margin.
    localparam int SETTLE_CYCLES = 100;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [sws_pkg::STAMP_W-1:0]   s_start_stamp = '0;
    logic [sws_pkg::STAMP_W-1:0]   s_end_stamp = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [sws_pkg::DUR_W-1:0]     m_latest_ns;
    logic [sws_pkg::DUR_W-1:0]     m_mean_ns;
    logic [sws_pkg::DUR_W-1:0]     m_min_ns;
    logic [sws_pkg::DUR_W-1:0]     m_max_ns;
    logic [sws_pkg::VCNT_W-1:0]    m_valid_count;
    logic                          m_clamped;

    frame_stats_tracker tracker = new();

    // While this is set, neither side inserts idle cycles, so the block also
    // sees stretches of back-to-back traffic.
    bit          calm = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned receive_stall = 0;

    sliding_window_frame_time_stats dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_stamp (s_start_stamp),
        .s_end_stamp   (s_end_stamp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_latest_ns   (m_latest_ns),
        .m_mean_ns     (m_mean_ns),
        .m_min_ns      (m_min_ns),
        .m_max_ns      (m_max_ns),
        .m_valid_count (m_valid_count),
        .m_clamped     (m_clamped)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long pause that can
    // outlast the block's processing time.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Offer one frame and hold it until the block takes it. The word is
    // handed to the tracker at the accepting edge. If no gap follows, valid
    // simply stays high for the next word.
    task automatic send_frame(input logic [sws_pkg::STAMP_W-1:0] start_ns,
                              input logic [sws_pkg::STAMP_W-1:0] end_ns);
        int unsigned gap;
        s_valid       <= 1'b1;
        s_start_stamp <= start_ns;
        s_end_stamp   <= end_ns;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_frame(start_ns, end_ns);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering words until every outstanding result has come back. Valid
    // stays low while the results drain, so the next word is driven at a
    // later edge than the one that drops valid.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_stats.size() != 0) @(posedge aclk);
    endtask

    // Result side: check each word taken, then decide whether the next cycles
    // are a stall. Stalls also fall while the block is busy or idle.
    initial begin
        frame_stats_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.latest_ns = m_latest_ns;
                got.mean_ns   = m_mean_ns;
                got.min_ns    = m_min_ns;
                got.max_ns    = m_max_ns;
                got.count     = m_valid_count;
                got.clamp     = m_clamped;
                tracker.check_stats(got);
            end
            if (receive_stall > 0 && !calm) begin
                receive_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                receive_stall = calm ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.pending_stats.size());
            $display("sliding_window_frame_time_stats regression: fail");
            $finish;
        end
    end

    initial begin
        logic [sws_pkg::STAMP_W-1:0] start_ns;
        logic [sws_pkg::STAMP_W-1:0] end_ns;
        logic [sws_pkg::STAMP_W-1:0] span;
        int unsigned                 r;

        // Synchronous reset, held low from the start, then released once.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners. The first frame has zero duration; then the
        // largest duration that still fits in 32 bits and the smallest one
        // that does not. End stamps before start stamps wrap modulo 2^64 and
        // mostly saturate, except for the one-tick wrap from all ones to zero and one that lands on 2^32 - 1.
        send_frame(64'h0, 64'h0);
        send_frame(64'h0, 64'h0000_0000_FFFF_FFFF);
        send_frame(64'h0, 64'h0000_0001_0000_0000);
        send_frame(64'd100, 64'd50);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_frame(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'h8000_0000_0000_0000, 64'h8000_0000_FFFF_FFFF);
        send_frame(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_frame(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_frame(64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF);
        send_frame(64'd1_000_000, 64'd17_666_667);
        send_frame(64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF1);
        send_frame(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
        send_frame(64'hFFFF_FFFF_8000_0000, 64'h0000_0000_7FFF_FFFF);
        send_frame(64'd0, 64'd1);
        send_frame(64'd42, 64'd2);

        // Let the block run dry once before the random part.
        wait_for_drain();

        // Random frames with random 64-bit start stamps. Most spans are
        // plausible frame times or small values; some cover the whole 32-bit
        // range, some sit right at its top, and the rest saturate. The 1030 frames
        // wrap the 64-entry window many times over.
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            if (n % 200 == 100) calm = 1'b1;
            if (n % 200 == 140) calm = 1'b0;
            if (n == RANDOM_FRAMES / 2) wait_for_drain();
            r        = $urandom_range(0, 99);
            start_ns = {$urandom, $urandom};
            if (r < 45)
                span = 64'($urandom_range(8_000_000, 40_000_000));
            else if (r < 60)
                span = 64'($urandom_range(0, 1000));
            else if (r < 78)
                span = {32'h0, $urandom};
            else if (r < 85)
                span = 64'h0000_0000_FFFF_FFFF - $urandom_range(0, 255);
            else if (r < 92)
                span = 64'h0000_0001_0000_0000 + $urandom_range(0, 1_000_000);
            else
                span = {$urandom, $urandom};
            end_ns = start_ns + span;
            send_frame(start_ns, end_ns);
        end

        // All words are in: wait for the last results, then give the block
        // time to show any stray word it should not produce.
        calm = 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.pending_stats.size() != 0)
            tracker.report_mismatch("results still outstanding at the end");

        $display("Ran %0d frames through the %0d-entry window, %0d of them saturated;",
                 tracker.frames_noted, sws_pkg::HISTORY, tracker.saturated_frames);
        $display("checked %0d result words, %0d field mismatches found.",
                 tracker.results_checked, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("sliding_window_frame_time_stats regression: pass");
        else
            $display("sliding_window_frame_time_stats regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/sws_pkg.sv
src/sws_div.sv
src/sliding_window_frame_time_stats.sv
sim/testbench.sv
